/* rtl/core/multi_servo_pulse_sequencer_macros.svh */
// Assertion helpers shared by the sequencer modules.
// Each expects clk and rst_n in scope.
`ifndef MULTI_SERVO_PULSE_SEQUENCER_MACROS_SVH
`define MULTI_SERVO_PULSE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define MSPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/msps_pkg.sv */
`default_nettype none

package msps_pkg;

    localparam int DEF_MAX_SERVOS = 16;
    localparam int DEF_TICK_WIDTH = 16;

    localparam int FIELD_W      = 16;
    localparam int COUNT_W      = 5;
    localparam int SLOT_TOTAL_W = 21;

    localparam logic [COUNT_W-1:0] GAP_MARK        = 5'd16;
    localparam logic [COUNT_W-1:0] RST_SERVO_COUNT = 5'd8;
    localparam logic [FIELD_W-1:0] RST_FRAME_TICKS = 16'd40000;
    localparam logic [FIELD_W-1:0] RST_MIN_GAP     = 16'd100;

    typedef enum logic [1:0] {
        REG_SERVO_COUNT = 2'd0,
        REG_FRAME_TICKS = 2'd1,
        REG_MIN_GAP     = 2'd2,
        REG_RUN_ENABLE  = 2'd3
    } cfg_reg_e;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_e;

    typedef struct packed {
        logic               operation;
        logic [3:0]         servo_index;
        logic [FIELD_W-1:0] pulse_ticks;
        logic [FIELD_W-1:0] slot_ticks;
        logic               connected;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] servo_pins;
        logic [COUNT_W-1:0] active_servo;
        logic               in_gap;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] servo_count;
        logic [FIELD_W-1:0] frame_ticks;
        logic [FIELD_W-1:0] min_gap_ticks;
        logic               run_enable;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/msps_cfg_regs.sv */
`default_nettype none

module msps_cfg_regs
    import msps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [1:0]         wr_index,
    input  wire logic [FIELD_W-1:0] wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SERVO_COUNT: cfg_next.servo_count   = wr_data[COUNT_W-1:0];
                REG_FRAME_TICKS: cfg_next.frame_ticks   = wr_data;
                REG_MIN_GAP:     cfg_next.min_gap_ticks = wr_data;
                REG_RUN_ENABLE:  cfg_next.run_enable    = wr_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_count   <= RST_SERVO_COUNT;
            cfg_reg.frame_ticks   <= RST_FRAME_TICKS;
            cfg_reg.min_gap_ticks <= RST_MIN_GAP;
            cfg_reg.run_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/msps_engine.sv */
`default_nettype none
`include "multi_servo_pulse_sequencer_macros.svh"

module msps_engine
    import msps_pkg::*;
#(
    parameter int MAX_SERVOS = DEF_MAX_SERVOS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     res
);

    localparam int CW = $clog2(MAX_SERVOS + 2);
    localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
    localparam int TW = TICK_WIDTH;
    localparam int CUR_RST = (int'(RST_SERVO_COUNT) > MAX_SERVOS) ? MAX_SERVOS
                                                                   : int'(RST_SERVO_COUNT);
    localparam logic [31:0] FRAME_RST32 = 32'(RST_FRAME_TICKS);

    logic [TW-1:0]           pulse_tab_reg [MAX_SERVOS];
    logic [TW-1:0]           slot_tab_reg  [MAX_SERVOS];
    logic [MAX_SERVOS-1:0]   conn_tab_reg;

    logic [CW-1:0]           cur_reg,         cur_next;
    logic                    started_reg,     started_next;
    logic [TW-1:0]           next_start_reg,  next_start_next;
    logic [TW-1:0]           pulse_off_reg,   pulse_off_next;
    logic                    pulse_active_reg, pulse_active_next;
    logic [SLOT_TOTAL_W-1:0] slot_total_reg,  slot_total_next;
    logic [MAX_SERVOS-1:0]   pin_levels_reg,  pin_levels_next;

    logic [5:0]              sc6;
    logic [5:0]              cnt6;
    logic [CW-1:0]           count_eff;
    logic [5:0]              idx6;
    logic [IW-1:0]           wr_idx;
    logic                    wr_en;
    logic [31:0]             pulse32;
    logic [31:0]             slot32;
    logic [31:0]             frame32;
    logic [31:0]             gap32;
    logic [31:0]             rd_slot32;
    logic [CW-1:0]           slot_inc;
    logic [CW-1:0]           sel_slot;
    logic [IW-1:0]           sel_idx;
    logic [SLOT_TOTAL_W-1:0] total_base;
    logic [TW-1:0]           rd_pulse;
    logic [TW-1:0]           rd_slot;
    logic                    rd_conn;
    logic [MAX_SERVOS-1:0]   sel_onehot;
    logic [31:0]             pins32;
    logic [5:0]              cur6;

    // Effective servo count: 0 acts as 1, clamp to MAX_SERVOS.
    assign sc6  = {1'b0, cfg.servo_count};
    assign cnt6 = (sc6 == 6'd0) ? 6'd1
                : ((sc6 > 6'(MAX_SERVOS)) ? 6'(MAX_SERVOS) : sc6);
    assign count_eff = cnt6[CW-1:0];

    assign idx6    = {2'b00, item.servo_index};
    assign wr_idx  = idx6[IW-1:0];
    assign wr_en   = step && (item.operation == OP_WRITE) && (idx6 < 6'(MAX_SERVOS));
    assign pulse32 = 32'(item.pulse_ticks);
    assign slot32  = 32'(item.slot_ticks);
    assign frame32 = 32'(cfg.frame_ticks);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVOS; i++)
            begin
                pulse_tab_reg[i] <= '0;
                slot_tab_reg[i]  <= '0;
            end
            conn_tab_reg <= '0;
        end
        else if (wr_en)
        begin
            pulse_tab_reg[wr_idx] <= pulse32[TW-1:0];
            slot_tab_reg[wr_idx]  <= slot32[TW-1:0];
            conn_tab_reg[wr_idx]  <= item.connected;
        end
    end

    always_comb
    begin
        cur_next          = cur_reg;
        started_next      = started_reg;
        next_start_next   = next_start_reg;
        pulse_off_next    = pulse_off_reg;
        pulse_active_next = pulse_active_reg;
        slot_total_next   = slot_total_reg;
        pin_levels_next   = pin_levels_reg;

        slot_inc   = started_reg ? (cur_reg + 1'b1) : cur_reg;
        sel_slot   = (slot_inc > count_eff) ? '0 : slot_inc;
        total_base = (slot_inc > count_eff) ? '0 : slot_total_reg;
        sel_idx    = sel_slot[IW-1:0];
        rd_pulse   = pulse_tab_reg[sel_idx];
        rd_slot    = slot_tab_reg[sel_idx];
        rd_conn    = conn_tab_reg[sel_idx];
        rd_slot32  = 32'(rd_slot);
        sel_onehot = '0;
        sel_onehot[sel_idx] = 1'b1;

        if ({5'b0, cfg.frame_ticks} < slot_total_reg)
            gap32 = 32'(cfg.min_gap_ticks);
        else
            gap32 = 32'(cfg.frame_ticks - slot_total_reg[FIELD_W-1:0]);

        if (step && (item.operation == OP_TICK))
        begin
            if (!cfg.run_enable)
            begin
                cur_next          = count_eff;
                started_next      = 1'b0;
                next_start_next   = frame32[TW-1:0];
                pulse_off_next    = '0;
                pulse_active_next = 1'b0;
                slot_total_next   = '0;
                pin_levels_next   = '0;
            end
            else
            begin
                // pulse countdown first, so a pulse ending with its slot frees the start
                if (pulse_active_reg)
                begin
                    if (pulse_off_reg != '0)
                        pulse_off_next = pulse_off_reg - 1'b1;
                    if (pulse_off_next == '0)
                    begin
                        pin_levels_next   = '0;
                        pulse_active_next = 1'b0;
                    end
                end
                if (next_start_reg != '0)
                    next_start_next = next_start_reg - 1'b1;

                if ((next_start_next == '0) && !pulse_active_next)
                begin
                    started_next = 1'b1;
                    if (slot_inc != count_eff)
                    begin
                        cur_next = sel_slot;
                        if (rd_conn && (rd_pulse != '0))
                        begin
                            pin_levels_next   = pin_levels_next | sel_onehot;
                            pulse_active_next = 1'b1;
                            pulse_off_next    = rd_pulse;
                        end
                        next_start_next = rd_slot;
                        slot_total_next = total_base + rd_slot32[SLOT_TOTAL_W-1:0];
                    end
                    else
                    begin
                        cur_next          = slot_inc;
                        pulse_active_next = 1'b0;
                        pulse_off_next    = '0;
                        next_start_next   = gap32[TW-1:0];
                    end
                end
            end
        end

        pins32 = 32'(pin_levels_next);
        cur6   = 6'(cur_next);
        res.servo_pins = pins32[FIELD_W-1:0];
        if (cur_next < count_eff)
        begin
            res.active_servo = cur6[COUNT_W-1:0];
            res.in_gap       = 1'b0;
        end
        else
        begin
            res.active_servo = GAP_MARK;
            res.in_gap       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg          <= CW'(CUR_RST);
            started_reg      <= 1'b0;
            next_start_reg   <= FRAME_RST32[TW-1:0];
            pulse_off_reg    <= '0;
            pulse_active_reg <= 1'b0;
            slot_total_reg   <= '0;
            pin_levels_reg   <= '0;
        end
        else
        begin
            cur_reg          <= cur_next;
            started_reg      <= started_next;
            next_start_reg   <= next_start_next;
            pulse_off_reg    <= pulse_off_next;
            pulse_active_reg <= pulse_active_next;
            slot_total_reg   <= slot_total_next;
            pin_levels_reg   <= pin_levels_next;
        end
    end

    `MSPS_ASSERT_NOW(a_pin_needs_pulse, pin_levels_reg != '0, pulse_active_reg, "pin high with no pulse running")
    `MSPS_ASSERT_NOW(a_one_pin_high, 1'b1, $onehot0(pin_levels_reg), "more than one pin high")
    `MSPS_ASSERT_NOW(a_pulse_count_live, pulse_active_reg, pulse_off_reg != '0, "active pulse with empty countdown")

endmodule

`default_nettype wire

/* rtl/core/multi_servo_pulse_sequencer.sv */
// Channel   Signals                           Width    Transaction
// item      item_valid item_ready item        in_item_t  tick or table write
// result    result_valid result_ready result  out_item_t pins and slot after each item
// cfg       cfg_valid cfg_ready cfg_index/data 2 / 16   register write, always ready
//
// One item per cycle sustained while result_ready holds; each item gives one result after acceptance
// (input register, then sequencer update into the result register).
// Reset is asynchronous: sequencer idle, tables zero, registers at defaults.
// A stalled result holds the result register; the input register keeps taking items
// until it is also occupied.
`default_nettype none
`include "multi_servo_pulse_sequencer_macros.svh"

module multi_servo_pulse_sequencer
    import msps_pkg::*;
#(
    parameter int MAX_SERVOS = DEF_MAX_SERVOS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire in_item_t           item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output out_item_t               result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data
);

    in_item_t  in_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t res_reg;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_comb;
    cfg_t      cfg;
    logic      advance;

    assign cfg_ready    = 1'b1;
    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    msps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    msps_engine #(
        .MAX_SERVOS (MAX_SERVOS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_reg <= item;
        if (advance)
            res_reg <= res_comb;
    end

    `MSPS_ASSERT_NEXT(a_accept_loads, item_valid && item_ready, in_valid_reg, "accepted item not held")
    `MSPS_ASSERT_NEXT(a_stall_keeps_item, in_valid_reg && !advance, in_valid_reg, "stalled item dropped")
    `MSPS_ASSERT_NEXT(a_advance_fills, advance, res_valid_reg, "processed item gave no result")

endmodule

`default_nettype wire
